FILE: rtl/core/sli_pkg.sv
// shared types, field widths and codes for the sorted list unit
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 40;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/sli_ctrl.sv
// controller state machine for the sorted list unit
`timescale 1ns / 1ps
`default_nettype none

module sli_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output sli_pkg::cmd_t    cmd
);
    import sli_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   commit;

    assign accept = in_valid && ready_reg;
    // result register must be free or draining this cycle
    assign commit = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready   = ready_reg;
    assign out_valid  = out_valid_reg;
    assign cmd.load   = accept;
    assign cmd.eval   = (state_reg == ST_EVAL);
    assign cmd.commit = commit;

endmodule

`default_nettype wire

FILE: rtl/core/sli_datapath.sv
// entry cells, compare flags and result register of the sorted list unit
`timescale 1ns / 1ps
`default_nettype none

module sli_datapath #(
    parameter int DEPTH = sli_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire sli_pkg::cmd_t                         cmd,
    input  wire logic        [sli_pkg::KIND_W-1:0]     in_kind,
    input  wire logic signed [sli_pkg::VALUE_W-1:0]    in_value,
    input  wire logic        [sli_pkg::INDEX_W-1:0]    in_index,
    output logic             [sli_pkg::STATUS_W-1:0]   res_status,
    output logic             [sli_pkg::COUNT_W-1:0]    res_count,
    output logic signed      [sli_pkg::VALUE_W-1:0]    res_read_value
);
    import sli_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int XW = (IW > INDEX_W) ? IW : INDEX_W;

    logic signed [VALUE_W-1:0] entries_reg [DEPTH];
    logic signed [VALUE_W-1:0] entries_next [DEPTH];
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;

    logic [KIND_W-1:0]         kind_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [INDEX_W-1:0]        index_reg;

    // per-cell flags: at or after the insert point, at or after the removal point, equal
    logic [DEPTH-1:0]          after_reg;
    logic [DEPTH-1:0]          after_next;
    logic [DEPTH-1:0]          ge_reg;
    logic [DEPTH-1:0]          ge_next;
    logic [DEPTH-1:0]          eq_reg;
    logic [DEPTH-1:0]          eq_next;

    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic [COUNT_W-1:0]        res_count_reg;
    logic signed [VALUE_W-1:0] read_value_reg;
    logic signed [VALUE_W-1:0] read_value_next;

    logic                      full;
    logic                      found;
    logic [XW-1:0]             idx_ext;
    logic                      idx_ok;
    logic [CW+COUNT_W-1:0]     count_ext;

    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            after_next[k] = (k >= int'(count_reg)) || (entries_reg[k] > value_reg);
            ge_next[k]    = (k < int'(count_reg)) && (entries_reg[k] >= value_reg);
            eq_next[k]    = (k < int'(count_reg)) && (entries_reg[k] == value_reg);
        end
    end

    assign full    = (count_reg >= CW'(DEPTH));
    assign found   = |eq_reg;
    assign idx_ext = XW'(index_reg);
    assign idx_ok  = ({1'b0, idx_ext} < (XW + 1)'(DEPTH))
                  && ((XW + CW)'(idx_ext) < (XW + CW)'(count_reg));

    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            entries_next[k] = entries_reg[k];
        end
        count_next      = count_reg;
        status_next     = STATUS_OK;
        read_value_next = '0;
        case (kind_reg)
            KIND_INSERT:
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    // cells past the insert point take their lower neighbor
                    entries_next[0] = after_reg[0] ? value_reg : entries_reg[0];
                    for (int k = 1; k < DEPTH; k++)
                    begin
                        if (after_reg[k])
                        begin
                            entries_next[k] = after_reg[k-1] ? entries_reg[k-1] : value_reg;
                        end
                    end
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_REMOVE:
            begin
                if (!found)
                begin
                    status_next = STATUS_NOT_FOUND;
                end
                else
                begin
                    // sorted list: first entry at or above the value is the first match
                    for (int k = 0; k < DEPTH - 1; k++)
                    begin
                        if (ge_reg[k])
                        begin
                            entries_next[k] = entries_reg[k+1];
                        end
                    end
                    count_next = count_reg - CW'(1);
                end
            end
            KIND_READ:
            begin
                if (idx_ok)
                begin
                    read_value_next = entries_reg[idx_ext[IW-1:0]];
                end
                else
                begin
                    status_next = STATUS_RANGE;
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            value_reg <= in_value;
            index_reg <= in_index;
        end
        if (cmd.eval)
        begin
            after_reg <= after_next;
            ge_reg    <= ge_next;
            eq_reg    <= eq_next;
        end
        if (cmd.commit)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                entries_reg[k] <= entries_next[k];
            end
            status_reg     <= status_next;
            res_count_reg  <= count_ext[COUNT_W-1:0];
            read_value_reg <= read_value_next;
        end
    end

    assign res_status     = status_reg;
    assign res_count      = res_count_reg;
    assign res_read_value = read_value_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_list_insert_remove_unit.sv
// top level of the sorted list unit: stream ports, controller and datapath
`timescale 1ns / 1ps
`default_nettype none

// Sorted list unit. Holds up to DEPTH signed 32-bit values in ascending order.
// Each input transaction is one command: insert (kind 0) places the value after
// all entries less than or equal to it, remove (kind 1) deletes the first entry
// equal to the value, read (kind 2) returns the entry at the given index. Each
// command yields exactly one output transaction with the status (ok, full, not
// found, index out of range), the entry count after the command and the read
// value (zero unless a read succeeds). An unused kind code changes nothing and
// reports ok. A command is accepted, then compared in every entry cell at once,
// then the cells are shifted and the result register loaded; the next command
// is accepted the cycle after that, so only one command is in flight at a time,
// following the controller's compare-then-shift sequence. The result register
// frees the input side while a result waits to be taken; a held-off result
// stalls only the shift step of the following command. Entry cells need no
// clearing after reset: only entries below the count are read.

module sorted_list_insert_remove_unit #(
    parameter int DEPTH = sli_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command side
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [31:0] value, [35:32] index, [39:36] zero
    input  wire logic [sli_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] kind
    input  wire logic [sli_pkg::S_TUSER_W-1:0]   s_tuser,
    // result side
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [1:0] status, [6:2] count, [38:7] read_value, [39] zero
    output logic [sli_pkg::M_TDATA_W-1:0]        m_tdata
);
    import sli_pkg::*;

    cmd_t                      cmd;
    logic signed [VALUE_W-1:0] in_value;
    logic [INDEX_W-1:0]        in_index;
    logic [STATUS_W-1:0]       res_status;
    logic [COUNT_W-1:0]        res_count;
    logic signed [VALUE_W-1:0] res_read_value;

    // unpack the command fields
    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_index = s_tdata[VALUE_W+INDEX_W-1:VALUE_W];

    sli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    sli_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_kind        (s_tuser),
        .in_value       (in_value),
        .in_index       (in_index),
        .res_status     (res_status),
        .res_count      (res_count),
        .res_read_value (res_read_value)
    );

    // pack the result fields, lowest first
    assign m_tdata = {1'b0, res_read_value, res_count, res_status};

endmodule

`default_nettype wire

FILE: rtl/core/sli_checker.sv
// port-level checks for the sorted list unit and their bind
`timescale 1ns / 1ps
`default_nettype none

module sli_checker #(
    parameter int DEPTH = sli_pkg::DEPTH_DEFAULT
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [sli_pkg::M_TDATA_W-1:0]   m_tdata
);
    import sli_pkg::*;

    localparam logic [COUNT_W-1:0] DEPTH_LOW = COUNT_W'(DEPTH);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one command in flight: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while another is in flight");

    // a full report always shows a full list
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == STATUS_FULL) |-> (m_tdata[6:2] == DEPTH_LOW))
        else $error("full status with a count below depth");

    // any error status carries a zero read value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != STATUS_OK) |-> (m_tdata[38:7] == '0))
        else $error("nonzero read value with an error status");

endmodule

bind sorted_list_insert_remove_unit sli_checker #(
    .DEPTH (DEPTH)
) u_sli_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
